FILE: hdl/infix_to_postfix_converter_core_macros.svh
// Assertion macros used by the infix-to-postfix converter datapath
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset
`define I2P_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define I2P_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/i2p_pkg.sv
// Shared types, character codes and helper functions of the infix-to-postfix converter
package i2p_pkg;

   // ASCII codes of the special characters
   localparam logic [7:0] CHAR_LPAR = 8'h28;
   localparam logic [7:0] CHAR_RPAR = 8'h29;
   localparam logic [7:0] CHAR_MUL  = 8'h2A;
   localparam logic [7:0] CHAR_ADD  = 8'h2B;
   localparam logic [7:0] CHAR_SUB  = 8'h2D;
   localparam logic [7:0] CHAR_DIV  = 8'h2F;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;

   localparam int unsigned CODE_W = 3;

   // Operator codes held on the stack
   typedef enum logic [CODE_W-1:0] {
      OP_LPAR = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_code_type;

   // Character classes of a request
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_ALNUM,
      CLS_LPAR,
      CLS_RPAR,
      CLS_OP,
      CLS_EQ
   } char_class_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_CHK,
      ST_PUSH,
      ST_EMIT_EQ,
      ST_FINISH
   } state_type;

   // Source of an emitted character
   typedef enum logic [1:0] {
      SEL_IN,
      SEL_TOP,
      SEL_EQ
   } emit_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic         latch;
      logic         rd;
      logic         pop;
      logic         push;
      logic         emit;
      emit_sel_type emit_sel;
      logic         flush;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      char_class_type in_class;
      char_class_type cur_class;
      logic           count_zero;
      logic           top_is_lpar;
      logic           top_lower;
      logic           pend_valid;
      logic           out_free;
   } status_type;

   function automatic char_class_type class_of(input logic [7:0] c);
      char_class_type cls;
      cls = CLS_OTHER;
      if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h30 && c <= 8'h39))
         cls = CLS_ALNUM;
      else if (c == CHAR_LPAR)
         cls = CLS_LPAR;
      else if (c == CHAR_RPAR)
         cls = CLS_RPAR;
      else if (c == CHAR_ADD || c == CHAR_SUB || c == CHAR_MUL || c == CHAR_DIV)
         cls = CLS_OP;
      else if (c == CHAR_EQ)
         cls = CLS_EQ;
      return cls;
   endfunction

   // Stack code of a character; anything not an operator maps to '('
   function automatic op_code_type code_of(input logic [7:0] c);
      op_code_type code;
      code = OP_LPAR;
      if (c == CHAR_ADD)
         code = OP_ADD;
      else if (c == CHAR_SUB)
         code = OP_SUB;
      else if (c == CHAR_MUL)
         code = OP_MUL;
      else if (c == CHAR_DIV)
         code = OP_DIV;
      return code;
   endfunction

   function automatic logic [1:0] prec_of(input logic [CODE_W-1:0] code);
      logic [1:0] p;
      p = 2'd0;
      if (code == OP_MUL || code == OP_DIV)
         p = 2'd2;
      else if (code == OP_ADD || code == OP_SUB)
         p = 2'd1;
      return p;
   endfunction

   function automatic logic [7:0] char_of(input logic [CODE_W-1:0] code);
      logic [7:0] ch;
      ch = CHAR_LPAR;
      if (code == OP_ADD)
         ch = CHAR_ADD;
      else if (code == OP_SUB)
         ch = CHAR_SUB;
      else if (code == OP_MUL)
         ch = CHAR_MUL;
      else if (code == OP_DIV)
         ch = CHAR_DIV;
      return ch;
   endfunction

endpackage

FILE: hdl/infix_to_postfix_converter_core.sv
// Top level of the shunting-yard infix-to-postfix converter
//
// Usage:
//   req_* channel takes one ASCII character of an infix expression per request.
//   rsp_* channel returns postfix characters: rsp_tdata is the character,
//   rsp_tlast marks the last character caused by one request and rsp_tuser is
//   the sticky stack overflow flag. Letters and digits pass straight through,
//   '(' and + - * / go onto the stack, ')' unwinds to its '(', '=' flushes all.
// Timing:
//   One request at a time. A letter or digit passes IDLE and FINISH; '(' adds PUSH.
//   ')', '=' and an operator run the pop loop, then '=' adds EMIT_EQ and an
//   operator PUSH. Each character popped and emitted takes a stack RAM read
//   (POP_RD), then a decision (POP_CHK). Each result waits in a holding slot
//   until the next one is known or the request ends, then is registered out.
// Reset:
//   Synchronous reset empties the stack and clears the overflow flag and the
//   output register; the stack RAM contents are not cleared.
// Stalls:
//   A stalled rsp_tready holds the current result; the core waits wherever it
//   next needs to move a character out and takes no new request until done.
module infix_to_postfix_converter_core #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   output logic       rsp_tuser    // [0] overflow
);

   i2p_pkg::cmd_type    cmd;
   i2p_pkg::status_type status;

   // Sequencer
   i2p_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Stack and output path
   i2p_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: hdl/i2p_ram.sv
// Generic single-write, single-read RAM with registered read data
module i2p_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we)
         mem_ff[waddr] <= wdata;
   end

   // Registered read port, holds while not read
   always_ff @(posedge clock) begin
      if (re)
         rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/i2p_ctrl.sv
// Controller state machine of the infix-to-postfix converter
module i2p_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  i2p_pkg::status_type status,
   output i2p_pkg::cmd_type    cmd
);

   i2p_pkg::state_type state_ff, state_in;
   logic               can_emit;

   // State register
   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= i2p_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   // A new character may enter the pending slot once the old one has a place
   assign can_emit = !status.pend_valid || status.out_free;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.emit_sel = i2p_pkg::SEL_TOP;
      unique case (state_ff)
         i2p_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               unique case (status.in_class)
                  i2p_pkg::CLS_ALNUM: begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = i2p_pkg::SEL_IN;
                     state_in     = i2p_pkg::ST_FINISH;
                  end
                  i2p_pkg::CLS_LPAR:  state_in = i2p_pkg::ST_PUSH;
                  i2p_pkg::CLS_RPAR,
                  i2p_pkg::CLS_OP,
                  i2p_pkg::CLS_EQ:    state_in = i2p_pkg::ST_POP_RD;
                  default:            state_in = i2p_pkg::ST_IDLE;
               endcase
            end
         end
         // Read the top of stack, or end the pop loop on an empty stack
         i2p_pkg::ST_POP_RD: begin
            if (status.count_zero) begin
               unique case (status.cur_class)
                  i2p_pkg::CLS_OP: state_in = i2p_pkg::ST_PUSH;
                  i2p_pkg::CLS_EQ: state_in = i2p_pkg::ST_EMIT_EQ;
                  default:         state_in = i2p_pkg::ST_FINISH;
               endcase
            end else begin
               cmd.rd   = 1'b1;
               state_in = i2p_pkg::ST_POP_CHK;
            end
         end
         // Decide on the top entry
         i2p_pkg::ST_POP_CHK: begin
            unique case (status.cur_class)
               i2p_pkg::CLS_RPAR: begin
                  if (status.top_is_lpar) begin
                     cmd.pop  = 1'b1;
                     state_in = i2p_pkg::ST_FINISH;
                  end else if (can_emit) begin
                     cmd.pop  = 1'b1;
                     cmd.emit = 1'b1;
                     state_in = i2p_pkg::ST_POP_RD;
                  end
               end
               i2p_pkg::CLS_OP: begin
                  if (status.top_is_lpar || status.top_lower) begin
                     state_in = i2p_pkg::ST_PUSH;
                  end else if (can_emit) begin
                     cmd.pop  = 1'b1;
                     cmd.emit = 1'b1;
                     state_in = i2p_pkg::ST_POP_RD;
                  end
               end
               default: begin
                  if (can_emit) begin
                     cmd.pop  = 1'b1;
                     cmd.emit = 1'b1;
                     state_in = i2p_pkg::ST_POP_RD;
                  end
               end
            endcase
         end
         i2p_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = i2p_pkg::ST_FINISH;
         end
         i2p_pkg::ST_EMIT_EQ: begin
            if (can_emit) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = i2p_pkg::SEL_EQ;
               state_in     = i2p_pkg::ST_FINISH;
            end
         end
         // Hand the pending character over marked last
         i2p_pkg::ST_FINISH: begin
            if (!status.pend_valid) begin
               state_in = i2p_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = i2p_pkg::ST_IDLE;
            end
         end
         default: state_in = i2p_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/i2p_dpath.sv
// Datapath of the infix-to-postfix converter: operator stack, pending slot, output register
`include "infix_to_postfix_converter_core_macros.svh"

module i2p_dpath #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser,
   input  i2p_pkg::cmd_type    cmd,
   output i2p_pkg::status_type status
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   logic [7:0]                   char_ff;
   logic [CW-1:0]                count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [7:0]                   pend_char_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [7:0]                   out_char_ff;
   logic                         out_last_ff;
   logic                         out_ovf_ff;
   logic                         out_load;
   logic                         full;
   logic [CW-1:0]                count_m1;
   logic [i2p_pkg::CODE_W-1:0]   top_code;
   logic [i2p_pkg::CODE_W-1:0]   push_code;
   i2p_pkg::op_code_type         cur_code;
   i2p_pkg::char_class_type      cur_class;
   logic [7:0]                   emit_char;

   // Current request character
   always_ff @(posedge clock) begin
      if (cmd.latch)
         char_ff <= req_tdata;
   end

   assign cur_class = i2p_pkg::class_of(char_ff);
   assign cur_code  = i2p_pkg::code_of(char_ff);
   assign push_code = (cur_class == i2p_pkg::CLS_LPAR) ? i2p_pkg::OP_LPAR : cur_code;

   // Stack pointer and sticky overflow
   assign full     = (count_ff == CW'(STACK_DEPTH));
   assign count_m1 = count_ff - CW'(1);

   always_comb begin
      count_in = count_ff;
      if (cmd.push && !full)
         count_in = count_ff + CW'(1);
      else if (cmd.pop)
         count_in = count_m1;
   end

   assign ovf_in = ovf_ff | (cmd.push & full);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Operator stack storage
   i2p_ram #(
      .WIDTH (i2p_pkg::CODE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (cmd.push && !full),
      .waddr (count_ff[AW-1:0]),
      .wdata (push_code),
      .re    (cmd.rd),
      .raddr (count_m1[AW-1:0]),
      .rdata (top_code)
   );

   // Character entering the pending slot
   always_comb begin
      unique case (cmd.emit_sel)
         i2p_pkg::SEL_IN:  emit_char = req_tdata;
         i2p_pkg::SEL_EQ:  emit_char = i2p_pkg::CHAR_EQ;
         default:          emit_char = i2p_pkg::char_of(top_code);
      endcase
   end

   // Pending slot: one character held back until it is known whether it is last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.emit)
         pend_valid_in = 1'b1;
      else if (cmd.flush)
         pend_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         pend_valid_ff <= 1'b0;
      else
         pend_valid_ff <= pend_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit)
         pend_char_ff <= emit_char;
   end

   // Output register
   assign out_load = (cmd.emit && pend_valid_ff) || cmd.flush;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load)
         out_valid_in = 1'b1;
      else if (rsp_tready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_char_ff <= pend_char_ff;
         out_last_ff <= cmd.flush;
         out_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   // Status to the controller
   always_comb begin
      status             = '0;
      status.in_class    = i2p_pkg::class_of(req_tdata);
      status.cur_class   = cur_class;
      status.count_zero  = (count_ff == '0);
      status.top_is_lpar = (top_code == i2p_pkg::OP_LPAR);
      status.top_lower   = (i2p_pkg::prec_of(top_code) < i2p_pkg::prec_of(cur_code));
      status.pend_valid  = pend_valid_ff;
      status.out_free    = !out_valid_ff || rsp_tready;
   end

   // Checks
   `I2P_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> count_ff == '0 && !out_valid_ff, "reset left state")
   `I2P_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(STACK_DEPTH), "count beyond depth")
   `I2P_ASSERT(a_ovf_sticky, clock, reset, ovf_ff |=> ovf_ff, "overflow flag cleared")
   `I2P_ASSERT(a_full_push_ovf, clock, reset, cmd.push && full |=> ovf_ff, "full push not flagged")
   `I2P_ASSERT(a_emit_room, clock, reset, out_load |-> !out_valid_ff || rsp_tready, "output overwritten")
   `I2P_ASSERT(a_pop_nonempty, clock, reset, cmd.pop |-> count_ff != '0, "pop from empty stack")

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the infix-to-postfix converter: directed and random expressions
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned STACK_DEPTH    = 16;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 60;

   // One expected postfix character
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       ovf;
   } postfix_char_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_char
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_char
   logic       rsp_tlast;
   logic       rsp_tuser;            // [0] overflow

   // Shadow of the converter state
   i2p_pkg::op_code_type op_stack_m [STACK_DEPTH];
   int unsigned          op_depth = 0;
   bit                   ovf_m    = 1'b0;
   postfix_char_type     postfix_q [$];

   bit idle_en      = 1'b1;
   int mismatches   = 0;
   int sent_items   = 0;
   int stall_left   = 0;
   int stuck_cycles = 0;

   infix_to_postfix_converter_core #(.STACK_DEPTH(STACK_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Operator binding strength
   function automatic int op_rank(input i2p_pkg::op_code_type op);
      case (op)
         i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: return 2;
         i2p_pkg::OP_ADD, i2p_pkg::OP_SUB: return 1;
         default:                          return 0;
      endcase
   endfunction

   // Character printed for a stacked entry
   function automatic logic [7:0] op_symbol(input i2p_pkg::op_code_type op);
      case (op)
         i2p_pkg::OP_ADD: return i2p_pkg::CHAR_ADD;
         i2p_pkg::OP_SUB: return i2p_pkg::CHAR_SUB;
         i2p_pkg::OP_MUL: return i2p_pkg::CHAR_MUL;
         i2p_pkg::OP_DIV: return i2p_pkg::CHAR_DIV;
         default:         return i2p_pkg::CHAR_LPAR;
      endcase
   endfunction

   function automatic logic [7:0] rand_alnum();
      case ($urandom_range(0, 2))
         0:       return 8'(8'h30 + $urandom_range(0, 9));
         1:       return 8'(8'h41 + $urandom_range(0, 25));
         default: return 8'(8'h61 + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic logic [7:0] rand_operator();
      case ($urandom_range(0, 3))
         0:       return i2p_pkg::CHAR_ADD;
         1:       return i2p_pkg::CHAR_SUB;
         2:       return i2p_pkg::CHAR_MUL;
         default: return i2p_pkg::CHAR_DIV;
      endcase
   endfunction

   // Junk in the stream: any byte, or a structural character out of place
   function automatic logic [7:0] rand_noise();
      case ($urandom_range(0, 3))
         0:       return i2p_pkg::CHAR_LPAR;
         1:       return i2p_pkg::CHAR_RPAR;
         2:       return rand_operator();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_op(input i2p_pkg::op_code_type op);
      if (op_depth >= STACK_DEPTH)
         ovf_m = 1'b1;
      else begin
         op_stack_m[op_depth] = op;
         op_depth++;
      end
   endtask

   // Work out the postfix characters caused by one infix character
   task automatic predict_postfix(input logic [7:0] c);
      postfix_char_type     run_q [$];
      i2p_pkg::op_code_type top;
      i2p_pkg::op_code_type code;
      bit                   found;
      found = 1'b0;
      if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h30 && c <= 8'h39))
         run_q.push_back('{c, 1'b0, 1'b0});
      else if (c == i2p_pkg::CHAR_LPAR)
         push_op(i2p_pkg::OP_LPAR);
      else if (c == i2p_pkg::CHAR_RPAR) begin
         // unwind to the matching '(' or until empty
         while (op_depth != 0 && !found) begin
            op_depth--;
            top = op_stack_m[op_depth];
            if (top == i2p_pkg::OP_LPAR)
               found = 1'b1;
            else
               run_q.push_back('{op_symbol(top), 1'b0, 1'b0});
         end
      end else if (c == i2p_pkg::CHAR_ADD || c == i2p_pkg::CHAR_SUB ||
                   c == i2p_pkg::CHAR_MUL || c == i2p_pkg::CHAR_DIV) begin
         code = i2p_pkg::code_of(c);
         // left associative: pop equal or stronger operators
         while (op_depth != 0 && op_stack_m[op_depth-1] != i2p_pkg::OP_LPAR &&
                op_rank(op_stack_m[op_depth-1]) >= op_rank(code)) begin
            op_depth--;
            run_q.push_back('{op_symbol(op_stack_m[op_depth]), 1'b0, 1'b0});
         end
         push_op(code);
      end else if (c == i2p_pkg::CHAR_EQ) begin
         while (op_depth != 0) begin
            op_depth--;
            run_q.push_back('{op_symbol(op_stack_m[op_depth]), 1'b0, 1'b0});
         end
         run_q.push_back('{i2p_pkg::CHAR_EQ, 1'b0, 1'b0});
      end
      // flag as it stands after the whole request
      foreach (run_q[k]) begin
         run_q[k].ovf  = ovf_m;
         run_q[k].last = (k == run_q.size() - 1);
         postfix_q.push_back(run_q[k]);
      end
   endtask

   // Send one character, with an optional idle burst ahead of it
   task automatic send_char(input logic [7:0] c);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      predict_postfix(c);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do
         @(posedge clock);
      while (!req_tready);
      sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   // Mostly well-formed expressions with random content, some junk and cut-offs
   task automatic send_random_expression();
      int target;
      int terms;
      int depth;
      bit want_operand;
      bit finished;
      target       = $urandom_range(1, 6);
      terms        = 0;
      depth        = 0;
      want_operand = 1'b1;
      finished     = 1'b0;
      while (!finished) begin
         if ($urandom_range(0, 19) == 0)
            send_char(rand_noise());
         if (want_operand) begin
            if (depth < 4 && $urandom_range(0, 3) == 0) begin
               send_char(i2p_pkg::CHAR_LPAR);
               depth++;
            end else begin
               send_char(rand_alnum());
               terms++;
               want_operand = 1'b0;
            end
         end else if (depth > 0 && (terms >= target || $urandom_range(0, 2) == 0)) begin
            send_char(i2p_pkg::CHAR_RPAR);
            depth--;
         end else if (terms >= target) begin
            send_char(i2p_pkg::CHAR_EQ);
            finished = 1'b1;
         end else begin
            send_char(rand_operator());
            want_operand = 1'b1;
         end
         // cut the expression short now and then
         if (!finished && $urandom_range(0, 29) == 0) begin
            send_char(i2p_pkg::CHAR_EQ);
            finished = 1'b1;
         end
      end
   endtask

   task automatic test_operands();
      send_text("09AZaz");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h3A);
      send_char(8'h60);
      send_char(i2p_pkg::CHAR_EQ);
   endtask

   task automatic test_precedence();
      send_text("a-b+c*d/e=");
   endtask

   // Matched, unmatched (stack busy and empty) and left-over parentheses
   task automatic test_parentheses();
      send_text("(a+b)*c)");
      send_char(i2p_pkg::CHAR_RPAR);
      send_text("((x-y=");
   endtask

   task automatic test_random_expressions(input int n, input bit quiet);
      int start;
      start = sent_items;
      while (sent_items - start < n) begin
         idle_en = quiet ? 1'b0 : ($urandom_range(0, 4) != 0);
         send_random_expression();
      end
   endtask

   // Fill the stack, overflow it with '+' and '(', then flush the deepest run
   task automatic test_stack_overflow();
      idle_en = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++)
         send_char(i2p_pkg::CHAR_LPAR);
      send_char(i2p_pkg::CHAR_ADD);
      send_char(i2p_pkg::CHAR_LPAR);
      send_text("a=");
   endtask

   // Result checker and receiver pacing
   always @(posedge clock) begin
      postfix_char_type exp_char;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (postfix_q.size() == 0) begin
            $display("%0t: unexpected result, exp none, got out_char %h last %b ovf %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches++;
         end else begin
            exp_char = postfix_q.pop_front();
            if (rsp_tdata !== exp_char.ch) begin
               $display("%0t: out_char exp %h got %h", $time, exp_char.ch, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== exp_char.last) begin
               $display("%0t: last exp %b got %b", $time, exp_char.last, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== exp_char.ovf) begin
               $display("%0t: overflow exp %b got %b", $time, exp_char.ovf, rsp_tuser);
               mismatches++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
   end

   // Watchdog on cycles with no traffic on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no traffic for %0d cycles", $time, stuck_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operands();
      test_precedence();
      test_parentheses();
      test_random_expressions(230, 1'b0);
      test_stack_overflow();
      test_random_expressions(40, 1'b1);
      req_tvalid <= 1'b0;
      while (postfix_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
